/* rtl/cbm8k_pkg.sv */
// ----------------------------------------------------------------------------
// cbm8k_pkg
// shared constants and types for the 8 KiB page cartridge bank mapper
// ----------------------------------------------------------------------------
package cbm8k_pkg;

   localparam int BANK_BITS   = 11;
   localparam int NUM_PAGES   = 6;
   localparam int PAGE_SEL_W  = 3;
   localparam int ADDR_W      = 16;
   localparam int DATA_W      = 8;
   localparam int KIND_W      = 2;
   localparam int ROM_ADDR_W  = 24;
   localparam int OFFSET_W    = 13;
   localparam int MASK_W      = 11;
   localparam int OUTER_W     = 8;
   localparam int CALC_W      = 12;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [ADDR_W-1:0] REG_OUTER     = 16'hFFF0;
   localparam logic [ADDR_W-1:0] REG_PAIR_A    = 16'hFFFE;
   localparam logic [ADDR_W-1:0] REG_PAIR_B    = 16'hFFFF;
   localparam logic [ADDR_W-1:0] RAM_BASE      = 16'hC000;
   localparam logic [ADDR_W-1:0] MIRROR_TOGGLE = 16'h2000;
   localparam logic [3:0]        PAIR_SEL_MASK = 4'hF;

   localparam logic [MASK_W-1:0] MASK_RESET    = 11'd63;

   localparam logic [KIND_W-1:0] KIND_ROM_READ  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RAM_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RAM_WRITE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NO_EFFECT = 2'd3;

   localparam logic CSR_IDX_ROM_BANK_MASK = 1'b0;

   typedef logic [BANK_BITS-1:0] bank_type;

endpackage

/* rtl/cartridge_bank_mapper_8k.sv */
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_8k
// translates cpu bus accesses through six 8 KiB rom pages and an outer block
// ----------------------------------------------------------------------------
// pipeline: an accepted request passes the input register, then the result
//   register; rsp_stall high holds the result there
// throughput: one item per cycle unless stalled; bank update, lookup in one pass
// reset: synchronous, clears both stages, pages to 0,1,2,3,0,1, outer bank
//   to zero and the rom bank mask to 63
module cartridge_bank_mapper_8k (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [cbm8k_pkg::ADDR_W-1:0]        req_address,
   input  logic [cbm8k_pkg::DATA_W-1:0]        req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cbm8k_pkg::KIND_W-1:0]        rsp_kind,
   output logic [cbm8k_pkg::ROM_ADDR_W-1:0]    rsp_rom_address,
   output logic [cbm8k_pkg::ADDR_W-1:0]        rsp_ram_address,
   output logic [cbm8k_pkg::ADDR_W-1:0]        rsp_mirror_address,
   output logic [cbm8k_pkg::DATA_W-1:0]        rsp_ram_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cbm8k_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [cbm8k_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [cbm8k_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);
   import cbm8k_pkg::*;

   localparam int ROM_FULL_W = BANK_BITS + OFFSET_W;

   function automatic bank_type mask_bank(input logic [CALC_W-1:0] b,
                                          input logic [MASK_W-1:0] m);
      logic [CALC_W-1:0] t;
      t = b & CALC_W'(m);
      return BANK_BITS'(t);
   endfunction

   // configuration
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic               csr_wr;

   // input stage
   logic               in_valid_ff, in_valid_in;
   logic               in_op_ff;
   logic [ADDR_W-1:0]  in_addr_ff;
   logic [DATA_W-1:0]  in_data_ff;

   // state
   bank_type           page_ff [NUM_PAGES];
   bank_type           page_in [NUM_PAGES];
   logic [OUTER_W-1:0] outer_ff, outer_in;

   // result stage
   logic                  out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [ROM_ADDR_W-1:0] rom_ff, rom_in;
   logic [ADDR_W-1:0]     ram_ff, ram_in;
   logic [ADDR_W-1:0]     mirror_ff, mirror_in;
   logic [DATA_W-1:0]     rdata_ff, rdata_in;

   logic                  out_ready;
   logic                  advance;
   logic                  req_take;
   logic [PAGE_SEL_W-1:0] slot;
   bank_type              bank_rd;
   logic [ROM_FULL_W-1:0] rom_full;
   logic [CALC_W-1:0]     outer_base;
   logic [CALC_W-1:0]     pair_base;
   logic                  is_ram;

   assign pready   = 1'b1;
   assign csr_wr   = psel & penable & pwrite & pready
                     & (paddr[CSR_ADDR_W-1] == CSR_IDX_ROM_BANK_MASK);
   assign mask_in  = csr_wr ? MASK_W'(pwdata) : mask_ff;
   assign prdata   = (paddr[CSR_ADDR_W-1] == CSR_IDX_ROM_BANK_MASK)
                     ? CSR_DATA_W'(mask_ff) : '0;

   assign out_ready   = !out_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && out_ready;
   assign req_stall   = in_valid_ff && !out_ready;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   assign is_ram     = in_addr_ff >= RAM_BASE;
   assign slot       = in_addr_ff[ADDR_W-1 -: PAGE_SEL_W];
   assign rom_full   = {bank_rd, in_addr_ff[OFFSET_W-1:0]};
   assign outer_base = {2'b00, in_data_ff, 2'b00};
   assign pair_base  = {2'b00, outer_ff, 2'b00}
                       + CALC_W'({(in_data_ff[3:0] & PAIR_SEL_MASK), 1'b0});

   always_comb begin
      case (slot)
         3'd0: bank_rd = page_ff[0];
         3'd1: bank_rd = page_ff[1];
         3'd2: bank_rd = page_ff[2];
         3'd3: bank_rd = page_ff[3];
         3'd4: bank_rd = page_ff[4];
         3'd5: bank_rd = page_ff[5];
         default: bank_rd = '0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < NUM_PAGES; i++) begin
         page_in[i] = page_ff[i];
      end
      outer_in  = outer_ff;
      kind_in   = KIND_ROM_READ;
      rom_in    = '0;
      ram_in    = '0;
      mirror_in = '0;
      rdata_in  = '0;
      if (!in_op_ff) begin
         if (!is_ram) begin
            kind_in = KIND_ROM_READ;
            rom_in  = ROM_ADDR_W'(rom_full);
         end else begin
            kind_in = KIND_RAM_READ;
            ram_in  = in_addr_ff;
         end
      end else begin
         if (in_addr_ff == REG_OUTER) begin
            outer_in   = in_data_ff;
            page_in[0] = mask_bank(outer_base, mask_ff);
            page_in[1] = mask_bank(outer_base + CALC_W'(1), mask_ff);
            page_in[2] = mask_bank(outer_base + CALC_W'(2), mask_ff);
            page_in[3] = mask_bank(outer_base + CALC_W'(3), mask_ff);
            page_in[4] = mask_bank(outer_base, mask_ff);
            page_in[5] = mask_bank(outer_base + CALC_W'(1), mask_ff);
         end else if (in_addr_ff == REG_PAIR_A) begin
            page_in[2] = mask_bank(pair_base, mask_ff);
            page_in[3] = mask_bank(pair_base + CALC_W'(1), mask_ff);
         end else if (in_addr_ff == REG_PAIR_B) begin
            page_in[4] = mask_bank(pair_base, mask_ff);
            page_in[5] = mask_bank(pair_base + CALC_W'(1), mask_ff);
         end
         if (is_ram) begin
            kind_in   = KIND_RAM_WRITE;
            ram_in    = in_addr_ff;
            mirror_in = in_addr_ff ^ MIRROR_TOGGLE;
            rdata_in  = in_data_ff;
         end else begin
            kind_in = KIND_NO_EFFECT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= MASK_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         outer_ff     <= '0;
         page_ff[0]   <= BANK_BITS'(0);
         page_ff[1]   <= BANK_BITS'(1);
         page_ff[2]   <= BANK_BITS'(2);
         page_ff[3]   <= BANK_BITS'(3);
         page_ff[4]   <= BANK_BITS'(0);
         page_ff[5]   <= BANK_BITS'(1);
      end else begin
         mask_ff      <= mask_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            outer_ff <= outer_in;
            for (int i = 0; i < NUM_PAGES; i++) begin
               page_ff[i] <= page_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_opcode;
         in_addr_ff <= req_address;
         in_data_ff <= req_write_data;
      end
      if (advance) begin
         kind_ff   <= kind_in;
         rom_ff    <= rom_in;
         ram_ff    <= ram_in;
         mirror_ff <= mirror_in;
         rdata_ff  <= rdata_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_rom_address    = rom_ff;
   assign rsp_ram_address    = ram_ff;
   assign rsp_mirror_address = mirror_ff;
   assign rsp_ram_data       = rdata_ff;

endmodule

/* rtl/cbm8k_checker.sv */
// ----------------------------------------------------------------------------
// cbm8k_checker
// port level checks for the cartridge bank mapper
// ----------------------------------------------------------------------------
module cbm8k_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_opcode,
   input logic [cbm8k_pkg::ADDR_W-1:0]        req_address,
   input logic [cbm8k_pkg::DATA_W-1:0]        req_write_data,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [cbm8k_pkg::KIND_W-1:0]        rsp_kind,
   input logic [cbm8k_pkg::ROM_ADDR_W-1:0]    rsp_rom_address,
   input logic [cbm8k_pkg::ADDR_W-1:0]        rsp_ram_address,
   input logic [cbm8k_pkg::ADDR_W-1:0]        rsp_mirror_address,
   input logic [cbm8k_pkg::DATA_W-1:0]        rsp_ram_data
);
   import cbm8k_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_ram_address) && $stable(rsp_rom_address))
      else $error("stalled result changed");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a free result side never back-pressures the request side
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while result side is free");

   // outer register write seen at the output as a ram write after both stages
   a_outer_write: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode && req_address == REG_OUTER
         && !rsp_stall) ##1 !rsp_stall
      |=> rsp_valid && rsp_kind == KIND_RAM_WRITE
         && rsp_ram_data == $past(req_write_data, 2)
         && rsp_mirror_address == (REG_OUTER ^ MIRROR_TOGGLE))
      else $error("outer register write result wrong");

endmodule

bind cartridge_bank_mapper_8k cbm8k_checker u_cbm8k_checker (.*);
